// ===== rtl/fiat_shamir_round_verifier_top_macros.svh =====
// Assertion macros for the Fiat-Shamir round verifier checker
`ifndef FIAT_SHAMIR_ROUND_VERIFIER_TOP_MACROS_SVH
`define FIAT_SHAMIR_ROUND_VERIFIER_TOP_MACROS_SVH

// same-cycle implication
`define FSRV_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define FSRV_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/fsrv_pkg.sv =====
// Shared types and constants for the Fiat-Shamir round verifier
package fsrv_pkg;

    localparam int WORD_W    = 64;
    localparam int CNT_W     = $clog2(WORD_W);
    localparam int ROUND_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 2 * WORD_W;
    localparam int OUT_DATA_W = 8;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ROUND_W-1:0] round_t;

    localparam word_t  MODULUS_RST     = word_t'(2);
    localparam word_t  PUBLIC_KEY_RST  = '0;
    localparam round_t ROUND_COUNT_RST = round_t'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS     = 2'd0,
        CFG_PUBLIC_KEY  = 2'd1,
        CFG_ROUND_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LATCH,
        ST_MULTIPLY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic phase_mul;
        logic latch;
    } dp_ctrl_t;

endpackage

// ===== rtl/fsrv_modmul.sv =====
// Bit-serial modular multiply-accumulate lane: acc = (2*acc + bit*addend) mod m
module fsrv_modmul
(
    input  logic              clk,
    input  logic              clear,
    input  logic              step,
    input  logic              mul_bit,
    input  fsrv_pkg::word_t   addend,
    input  fsrv_pkg::word_t   modulus,
    output fsrv_pkg::word_t   acc
);

    localparam int SUM_W = fsrv_pkg::WORD_W + 2;

    fsrv_pkg::word_t  acc_reg;
    fsrv_pkg::word_t  acc_next;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m1;
    logic [SUM_W-1:0] m2;

    always_comb
    begin
        m1  = {2'b00, modulus};
        m2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (mul_bit ? {2'b00, addend} : '0);
        if (sum >= m2)
        begin
            acc_next = fsrv_pkg::word_t'(sum - m2);
        end
        else if (sum >= m1)
        begin
            acc_next = fsrv_pkg::word_t'(sum - m1);
        end
        else
        begin
            acc_next = fsrv_pkg::word_t'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/fsrv_datapath.sv =====
// Operand shift registers, two modmul lanes and the round check
module fsrv_datapath
(
    input  logic                clk,
    input  fsrv_pkg::dp_ctrl_t  ctrl,
    input  fsrv_pkg::word_t     commitment,
    input  logic                challenge,
    input  fsrv_pkg::word_t     response,
    input  fsrv_pkg::word_t     public_key,
    input  fsrv_pkg::word_t     modulus,
    output logic                round_pass
);

    localparam int W = fsrv_pkg::WORD_W;

    fsrv_pkg::word_t x_sh_reg;
    fsrv_pkg::word_t y_sh_reg;
    fsrv_pkg::word_t v_sh_reg;
    fsrv_pkg::word_t x_red_reg;
    fsrv_pkg::word_t y_red_reg;
    logic            e_reg;

    fsrv_pkg::word_t add0;
    fsrv_pkg::word_t add1;
    logic            bit0;
    logic            bit1;
    fsrv_pkg::word_t acc0;
    fsrv_pkg::word_t acc1;
    fsrv_pkg::word_t rhs;

    // reduce: lane0 = x mod n, lane1 = y mod n
    // multiply: lane0 = y*(y mod n), lane1 = v*(x mod n)
    always_comb
    begin
        if (ctrl.phase_mul)
        begin
            add0 = y_red_reg;
            bit0 = y_sh_reg[W-1];
            add1 = x_red_reg;
            bit1 = v_sh_reg[W-1];
        end
        else
        begin
            add0 = fsrv_pkg::word_t'(1);
            bit0 = x_sh_reg[W-1];
            add1 = fsrv_pkg::word_t'(1);
            bit1 = y_sh_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_sh_reg <= commitment;
            y_sh_reg <= response;
            v_sh_reg <= public_key;
            e_reg    <= challenge;
        end
        else if (ctrl.step)
        begin
            y_sh_reg <= {y_sh_reg[W-2:0], y_sh_reg[W-1]};
            if (ctrl.phase_mul)
            begin
                v_sh_reg <= {v_sh_reg[W-2:0], v_sh_reg[W-1]};
            end
            else
            begin
                x_sh_reg <= {x_sh_reg[W-2:0], x_sh_reg[W-1]};
            end
        end
        if (ctrl.latch)
        begin
            x_red_reg <= acc0;
            y_red_reg <= acc1;
        end
    end

    fsrv_modmul u_lane0
    (
        .clk     (clk),
        .clear   (ctrl.clear),
        .step    (ctrl.step),
        .mul_bit (bit0),
        .addend  (add0),
        .modulus (modulus),
        .acc     (acc0)
    );

    fsrv_modmul u_lane1
    (
        .clk     (clk),
        .clear   (ctrl.clear),
        .step    (ctrl.step),
        .mul_bit (bit1),
        .addend  (add1),
        .modulus (modulus),
        .acc     (acc1)
    );

    assign rhs        = e_reg ? acc1 : x_red_reg;
    assign round_pass = (modulus != '0) && (acc0 == rhs);

endmodule

// ===== rtl/fiat_shamir_round_verifier_top.sv =====
// Top level of the Fiat-Shamir identification round verifier
//
// Input stream (s_axis_*): one request per round; tdata carries the
// commitment x and the response y, tuser the challenge bit e.
// Output stream (m_axis_*): one request per round; tdata carries the
// round number, tuser the round pass and session accept flags, and tlast
// marks the end of a session (first failure or final round).
// Config channel (cfg_*): writes modulus, public key and round count;
// always ready; user writes only while no round is in flight, not enforced here.
// Each round runs two 64-step bit-serial modular lanes: a reduce pass
// (x mod N, y mod N) then a multiply pass (y*y and x*v mod N), one bit per
// cycle; the result is registered when the block leaves its finish state,
// and a new request is taken only once the block is back in idle.
// A finished result waits in the output register; if the receiver stalls,
// the block holds in its final state until the register frees up.
// Reset clears the session counter, loads config defaults (N = 2, v = 0,
// 7 rounds) and empties the output register.
module fiat_shamir_round_verifier_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fsrv_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // commitment, response
    input  logic [0:0]                         s_axis_tuser,   // challenge
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fsrv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // round_number, zero pad
    output logic [1:0]                         m_axis_tuser,   // round_pass, accepted
    output logic                               m_axis_tlast,   // session_done
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsrv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsrv_pkg::WORD_W-1:0]        cfg_data
);

    localparam int W = fsrv_pkg::WORD_W;

    fsrv_pkg::state_t   state_reg;
    fsrv_pkg::state_t   state_next;
    logic [fsrv_pkg::CNT_W-1:0] cnt_reg;
    logic [fsrv_pkg::CNT_W-1:0] cnt_next;
    fsrv_pkg::dp_ctrl_t ctrl;

    fsrv_pkg::word_t    modulus_reg;
    fsrv_pkg::word_t    public_key_reg;
    fsrv_pkg::round_t   round_count_reg;
    fsrv_pkg::round_t   rounds_seen_reg;
    fsrv_pkg::round_t   rounds_seen_next;

    logic               m_valid_reg;
    logic               m_valid_next;
    fsrv_pkg::round_t   number_reg;
    logic               pass_reg;
    logic               done_reg;
    logic               acc_ok_reg;

    logic               round_pass;
    fsrv_pkg::round_t   number;
    logic               done;
    logic               out_free;
    logic               emit;
    logic               cnt_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= fsrv_pkg::MODULUS_RST;
            public_key_reg  <= fsrv_pkg::PUBLIC_KEY_RST;
            round_count_reg <= fsrv_pkg::ROUND_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fsrv_pkg::CFG_MODULUS:     modulus_reg     <= cfg_data;
                fsrv_pkg::CFG_PUBLIC_KEY:  public_key_reg  <= cfg_data;
                fsrv_pkg::CFG_ROUND_COUNT: round_count_reg <= cfg_data[fsrv_pkg::ROUND_W-1:0];
                default:                   ;
            endcase
        end
    end

    assign cnt_last = (cnt_reg == fsrv_pkg::CNT_W'(W - 1));
    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == fsrv_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        emit       = 1'b0;
        unique case (state_reg)
            fsrv_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ctrl.load  = 1'b1;
                    ctrl.clear = 1'b1;
                    cnt_next   = '0;
                    state_next = fsrv_pkg::ST_REDUCE;
                end
            end
            fsrv_pkg::ST_REDUCE:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = fsrv_pkg::ST_LATCH;
                end
            end
            fsrv_pkg::ST_LATCH:
            begin
                ctrl.latch = 1'b1;
                ctrl.clear = 1'b1;
                cnt_next   = '0;
                state_next = fsrv_pkg::ST_MULTIPLY;
            end
            fsrv_pkg::ST_MULTIPLY:
            begin
                ctrl.step      = 1'b1;
                ctrl.phase_mul = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = fsrv_pkg::ST_FINISH;
                end
            end
            fsrv_pkg::ST_FINISH:
            begin
                ctrl.phase_mul = 1'b1;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = fsrv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fsrv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsrv_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    fsrv_datapath u_dp
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .commitment (s_axis_tdata[W-1:0]),
        .challenge  (s_axis_tuser[0]),
        .response   (s_axis_tdata[2*W-1:W]),
        .public_key (public_key_reg),
        .modulus    (modulus_reg),
        .round_pass (round_pass)
    );

    assign number = rounds_seen_reg + 1'b1;
    assign done   = !round_pass || (number >= round_count_reg);

    always_comb
    begin
        rounds_seen_next = rounds_seen_reg;
        m_valid_next     = m_valid_reg;
        if (emit)
        begin
            rounds_seen_next = done ? '0 : number;
            m_valid_next     = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_seen_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            rounds_seen_reg <= rounds_seen_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            number_reg <= number;
            pass_reg   <= round_pass;
            done_reg   <= done;
            acc_ok_reg <= done && round_pass;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(fsrv_pkg::OUT_DATA_W - fsrv_pkg::ROUND_W)'(0), number_reg};
    assign m_axis_tuser  = {acc_ok_reg, pass_reg};
    assign m_axis_tlast  = done_reg;

endmodule

// ===== rtl/fsrv_checker.sv =====
// Port-level checker for the Fiat-Shamir round verifier, bound to the top level
`include "fiat_shamir_round_verifier_top_macros.svh"

module fsrv_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fsrv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [1:0]                         m_axis_tuser,
    input logic                               m_axis_tlast
);

    // session accept only on the closing result
    `FSRV_ASSERT_IMP(a_accept_ends, clk, rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)

    // a failed round always closes the session
    `FSRV_ASSERT_IMP(a_fail_ends, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)

    // one round in flight at a time
    `FSRV_ASSERT_NXT(a_busy_after_req, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // stalled result holds
    `FSRV_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind fiat_shamir_round_verifier_top fsrv_checker u_fsrv_checker (.*);

// ===== bench/fsrv_round_checker.sv =====
// Round checker for the Fiat-Shamir verifier: tracks config, predicts each round, compares results
`timescale 1ns / 100ps

module fsrv_round_checker
    import fsrv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // commitment, response
    input  logic [0:0]              s_axis_tuser,   // challenge
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,   // round_number, zero pad
    input  logic [1:0]              m_axis_tuser,   // round_pass, accepted
    input  logic                    m_axis_tlast,   // session_done
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]       cfg_data,
    output int                      fault_count,
    output int                      rounds_pending
);

    typedef logic [2*WORD_W-1:0] wide_t;

    typedef struct packed {
        logic   pass;
        round_t number;
        logic   done;
        logic   accepted;
    } round_verdict_t;

    localparam int REPORT_LIMIT = 10;

    word_t          modulus_q;
    word_t          key_q;
    round_t         rounds_target;
    round_t         passed_run;
    int             fault_tally;
    round_verdict_t expected_rounds[$];

    function automatic round_verdict_t grade_round(word_t x, logic e, word_t y);
        round_verdict_t verdict;
        wide_t          n;
        wide_t          lhs;
        wide_t          rhs;
        int             number;
        number = int'(passed_run) + 1;
        n = wide_t'(modulus_q);
        if (modulus_q == '0)
            verdict.pass = 1'b0;
        else
        begin
            lhs = (wide_t'(y) * wide_t'(y)) % n;
            rhs = e ? ((wide_t'(x) % n) * (wide_t'(key_q) % n)) % n : wide_t'(x) % n;
            verdict.pass = (lhs == rhs);
        end
        verdict.number   = round_t'(number);
        verdict.done     = !verdict.pass || number >= int'(rounds_target);
        verdict.accepted = verdict.done && verdict.pass;
        passed_run = verdict.done ? '0 : round_t'(number);
        return verdict;
    endfunction

    task automatic note_fault(input logic had_want, input round_verdict_t want,
                              input round_verdict_t got);
        fault_tally++;
        if (fault_tally <= REPORT_LIMIT)
        begin
            if (had_want)
                $display("%0t: round mismatch, expected pass=%0d num=%0d done=%0d acc=%0d, got pass=%0d num=%0d done=%0d acc=%0d",
                         $time, want.pass, want.number, want.done, want.accepted,
                         got.pass, got.number, got.done, got.accepted);
            else
                $display("%0t: unexpected result pass=%0d num=%0d done=%0d acc=%0d",
                         $time, got.pass, got.number, got.done, got.accepted);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        round_verdict_t want;
        round_verdict_t got;
        if (!rst_n)
        begin
            modulus_q      = MODULUS_RST;
            key_q          = PUBLIC_KEY_RST;
            rounds_target  = ROUND_COUNT_RST;
            passed_run     = '0;
            fault_tally    = 0;
            expected_rounds.delete();
            fault_count    <= 0;
            rounds_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODULUS:     modulus_q = cfg_data;
                    CFG_PUBLIC_KEY:  key_q = cfg_data;
                    CFG_ROUND_COUNT: rounds_target = cfg_data[ROUND_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pass     = m_axis_tuser[0];
                got.number   = m_axis_tdata[ROUND_W-1:0];
                got.done     = m_axis_tlast;
                got.accepted = m_axis_tuser[1];
                if (expected_rounds.size() == 0)
                    note_fault(1'b0, got, got);
                else
                begin
                    want = expected_rounds.pop_front();
                    if (want != got)
                        note_fault(1'b1, want, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_rounds.push_back(grade_round(s_axis_tdata[WORD_W-1:0], s_axis_tuser[0],
                                                      s_axis_tdata[2*WORD_W-1:WORD_W]));
            rounds_pending <= expected_rounds.size();
            fault_count    <= fault_tally;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the Fiat-Shamir round verifier: clock, reset, round stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import fsrv_pkg::*;

    typedef logic [2*WORD_W-1:0] wide_t;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int TOTAL_ITEMS    = 1050;
    localparam int LATENCY_SLACK  = 140;
    localparam int HOLD_EVERY     = 450;
    localparam int HOLD_AT        = 100;
    localparam int LONG_HOLD      = 1500;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int FLAVOR_PLAIN     = 0;
    localparam int FLAVOR_NEGATE    = 1;
    localparam int FLAVOR_UNREDUCED = 2;
    localparam int FLAVOR_CORRUPT   = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // commitment, response
    logic [0:0]             s_axis_tuser;   // challenge
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // round_number, zero pad
    logic [1:0]             m_axis_tuser;   // round_pass, accepted
    logic                   m_axis_tlast;   // session_done
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WORD_W-1:0]      cfg_data;

    int     fault_count;
    int     rounds_pending;
    int     items_sent;
    int     send_calm;
    word_t  cur_n;
    word_t  cur_s;

    fiat_shamir_round_verifier_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fsrv_round_checker round_monitor
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fault_count    (fault_count),
        .rounds_pending (rounds_pending)
    );

    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic word_t mod_mul(word_t a, word_t b, word_t m);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return word_t'(p % wide_t'(m));
    endfunction

    // zero-gap stretches now and then so back-to-back traffic shows up too
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_round(input word_t x, input logic e, input word_t y);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= e;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // honest prover: x = r^2, y = r (e = 0) or r*s (e = 1), v = s^2; flavor then alters x or y
    task automatic offer_proof(input int flavor, input logic e);
        word_t r;
        word_t x;
        word_t y;
        if (cur_n == '0)
        begin
            x = rand_word();
            y = rand_word();
        end
        else
        begin
            r = rand_word() % cur_n;
            x = mod_mul(r, r, cur_n);
            y = e ? mod_mul(r, cur_s, cur_n) : r;
            if (flavor == FLAVOR_NEGATE && y != '0)
                y = cur_n - y;
            if (flavor == FLAVOR_UNREDUCED)
            begin
                if (x <= ~cur_n)
                    x = x + cur_n;
                if (y <= ~cur_n)
                    y = y + cur_n;
            end
            if (flavor == FLAVOR_CORRUPT)
                y = y ^ (word_t'(1) << $urandom_range(0, WORD_W - 1));
        end
        offer_round(x, e, y);
    endtask

    task automatic load_key(input word_t n, input word_t s, input logic fold);
        word_t v;
        if (n == '0)
            v = rand_word();
        else
        begin
            s = s % n;
            v = mod_mul(s, s, n);
            // with fold, key written at or above the modulus when v + n fits in a word
            if (fold && v <= ~n)
                v = v + n;
        end
        write_register(CFG_MODULUS, n);
        write_register(CFG_PUBLIC_KEY, v);
        cur_n = n;
        cur_s = s;
    endtask

    task automatic drain_rounds();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (rounds_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : sink
        int gap;
        int calm;
        int taken;
        m_axis_tready = 1'b0;
        calm = 0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // long back-pressure: block fills and stalls its input
            if (taken % HOLD_EVERY == HOLD_AT)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = draw_gap(calm);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    initial
    begin : stimulus
        word_t  n;
        word_t  w;
        round_t rc;
        int     roll;
        int     span;
        logic   clean;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        items_sent    = 0;
        send_calm     = 0;
        cur_n         = MODULUS_RST;
        cur_s         = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: N = 2, v = 0, seven rounds
        offer_round('0, 1'b0, '0);
        offer_round('1, 1'b1, '1);
        offer_round('1, 1'b0, '1);
        drain_rounds();

        // zero modulus: every round fails
        write_register(CFG_MODULUS, '0);
        offer_round('1, 1'b0, '1);
        offer_round('0, 1'b1, '0);
        drain_rounds();

        // unit modulus and zero round count (upper data bits set)
        write_register(CFG_MODULUS, word_t'(1));
        write_register(CFG_ROUND_COUNT, 64'hFFFF_FFFF_FFFF_FFC0);
        offer_round(rand_word(), 1'b1, rand_word());
        drain_rounds();

        // unused index, single-round sessions, key equal to full-scale modulus
        write_register(CFG_UNUSED, '1);
        write_register(CFG_ROUND_COUNT, word_t'(1));
        load_key('1, '0, 1'b1);
        offer_proof(FLAVOR_PLAIN, 1'b0);
        offer_proof(FLAVOR_PLAIN, 1'b1);
        offer_proof(FLAVOR_UNREDUCED, 1'b1);
        drain_rounds();

        write_register(CFG_ROUND_COUNT, word_t'(63));
        load_key(rand_word() | {1'b1, {(WORD_W-2){1'b0}}, 1'b1}, rand_word(), 1'b1);
        offer_proof(FLAVOR_PLAIN, 1'b0);
        offer_proof(FLAVOR_PLAIN, 1'b1);
        offer_proof(FLAVOR_NEGATE, 1'b1);
        offer_proof(FLAVOR_UNREDUCED, 1'b0);
        offer_proof(FLAVOR_CORRUPT, 1'b1);
        offer_proof(FLAVOR_PLAIN, 1'b0);
        offer_proof(FLAVOR_PLAIN, 1'b1);
        drain_rounds();

        // round count lowered below the running round number
        write_register(CFG_ROUND_COUNT, word_t'(2));
        offer_proof(FLAVOR_PLAIN, 1'b1);
        drain_rounds();

        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       n = word_t'($urandom_range(2, 255));
                    1:       n = word_t'($urandom_range(0, 1));
                    2:       n = '1;
                    3:       n = word_t'(2);
                    default:
                    begin
                        n = rand_word();
                        if (n < 2)
                            n = word_t'(2);
                    end
                endcase
                load_key(n, rand_word(), $urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 9))
                0:       rc = '0;
                1:       rc = '1;
                2:       rc = round_t'(1);
                3:       rc = round_t'($urandom_range(0, 63));
                default: rc = round_t'($urandom_range(1, 8));
            endcase
            w = ($urandom_range(0, 3) == 0) ? rand_word() : '0;
            w[ROUND_W-1:0] = rc;
            write_register(CFG_ROUND_COUNT, w);

            // long sessions only complete with well-formed rounds
            clean = (rc > round_t'(16));
            span = clean ? $urandom_range(64, 140) : $urandom_range(8, 50);
            repeat (span)
            begin
                roll = $urandom_range(0, 19);
                if (clean || roll < 12)
                    offer_proof(FLAVOR_PLAIN, 1'($urandom()));
                else if (roll < 14)
                    offer_proof(FLAVOR_NEGATE, 1'($urandom()));
                else if (roll < 16)
                    offer_proof(FLAVOR_UNREDUCED, 1'($urandom()));
                else if (roll < 18)
                    offer_proof(FLAVOR_CORRUPT, 1'($urandom()));
                else
                    offer_round(rand_word(), 1'($urandom()), rand_word());
            end
            drain_rounds();
        end

        repeat (LATENCY_SLACK) @(posedge clk);
        if (fault_count == 0 && rounds_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== fiat_shamir_round_verifier_top.f =====
+incdir+rtl
rtl/fsrv_pkg.sv
rtl/fsrv_modmul.sv
rtl/fsrv_datapath.sv
rtl/fiat_shamir_round_verifier_top.sv
rtl/fsrv_checker.sv
bench/fsrv_round_checker.sv
bench/testbench.sv
